// File: rtl/core/dqb_pkg.sv
// Shared types, codes and constants for the DMA descriptor queue with budget check.
// Used by dqb_alu, dma_descriptor_queue_budget and dqb_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqb_pkg;

  // default queue depth and limits of the request fields
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_SPLIT       = 5;

  // field widths
  localparam int LIMIT_W    = 16;
  localparam int OVH_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ALU_W      = 18;
  localparam int CHUNK_W    = 5;

  // chunk address stepping and zero-fill increment mode
  localparam logic [23:0] SRC_STEP  = 24'd512;
  localparam logic [15:0] DEST_STEP = 16'd256;
  localparam logic [7:0]  FILL_MODE = 8'h80;

  // register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RST       = 16'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_BLANK_RST = 16'd32768;
  localparam logic [OVH_W-1:0]   OVH_RST         = 11'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BLANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD    = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ARM   = 2'd1,
    OP_RESET = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_FILL   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_BUDGET,
    S_COUNT,
    S_WRITE,
    S_RESP,
    S_DRAIN_RD,
    S_DRAIN_OUT,
    S_FILL
  } state_t;

  // request word
  typedef struct packed {
    op_t         op;
    logic [23:0] src_addr;
    logic [15:0] dest_addr;
    logic [15:0] byte_length;
    logic [7:0]  incr_mode;
    logic [2:0]  split_log;
    logic        blanking;
  } in_item_t;

  // result word
  typedef struct packed {
    kind_t       kind;
    logic        status;
    logic [7:0]  out_mode;
    logic [15:0] out_dest;
    logic [23:0] out_src;
    logic [15:0] out_length;
    logic        last;
  } out_item_t;

  // one stored descriptor
  typedef struct packed {
    logic [7:0]  mode;
    logic [15:0] dest;
    logic [23:0] src;
    logic [15:0] len;
  } entry_t;

  // shared add and compare unit
  typedef struct packed {
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
    logic [LIMIT_W-1:0] lim;
  } alu_ctrl_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             gt;
  } alu_res_t;

endpackage

`default_nettype wire

// File: rtl/core/dma_descriptor_queue_budget.sv
// DMA descriptor queue with per-frame bandwidth admission, top level.
// Depends on dqb_pkg and dqb_alu.
//
// Usage: requests enter on in_valid/in_ready as one in_item_t word; results
// leave on out_valid/out_ready as out_item_t words, the last one of each
// request flagged by last. Limits and per-entry overhead are written on the
// cfg_we/cfg_index/cfg_wdata port while the block is idle.
// One request is worked at a time; in_ready is high only in the idle state.
// Steps per request: add runs sum, budget and count, then one queue write
// per chunk through the single memory write port, then its status word (a
// rejected add skips the writes); arm fill runs sum and budget; reset queue
// goes straight to its status word; drain does one memory read then one output
// load per stored descriptor, plus a fill word when armed; an empty drain gives one word.
// Budget and count checks run one after another through one shared 18-bit adder/comparator.
// The output register lets the next request be accepted while the final
// result still waits; a stalled receiver holds the sequencer in its emit
// state and nothing is dropped.
// Synchronous reset empties the queue, disarms the fill, clears the budget
// and restores the register defaults; the queue memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dma_descriptor_queue_budget #(
  parameter int QUEUE_DEPTH = dqb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dqb_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dqb_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [dqb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dqb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dqb_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  state_t               state;
  state_t               state_next;
  in_item_t             cur;
  logic [ALU_W-1:0]     acc;
  logic                 budget_fail;
  logic                 status_bit;
  logic [CNT_W-1:0]     entry_count;
  logic [LIMIT_W-1:0]   used_budget;
  logic                 fill_armed;
  logic [15:0]          fill_dest;
  logic [15:0]          fill_length;
  logic [LIMIT_W-1:0]   bw_limit;
  logic [LIMIT_W-1:0]   bw_limit_blank;
  logic [OVH_W-1:0]     entry_overhead;
  logic [CHUNK_W-1:0]   chunk_idx;
  logic [23:0]          wr_src;
  logic [15:0]          wr_dest;
  logic [CNT_W-1:0]     drain_idx;
  entry_t               rd_data;
  entry_t               mem [QUEUE_DEPTH];

  alu_ctrl_t            alu_ctrl;
  alu_res_t             alu_res;
  logic                 out_free;
  logic                 emit;
  out_item_t            emit_item;
  logic [CHUNK_W-1:0]   chunk_last;
  logic [CHUNK_W:0]     chunks;
  logic                 split_bad;
  logic                 add_fail;
  logic                 drain_at_end;
  entry_t               wr_entry;

  dqb_alu u_alu (
    .ctrl (alu_ctrl),
    .res  (alu_res)
  );

  // per-request derived values
  always_comb begin
    chunks       = (CHUNK_W + 1)'(1) << cur.split_log;
    chunk_last   = CHUNK_W'(chunks - 1'b1);
    split_bad    = cur.split_log > 3'(MAX_SPLIT);
    add_fail     = budget_fail | alu_res.gt | split_bad;
    drain_at_end = CNT_W'(drain_idx + 1'b1) == entry_count;
    out_free     = !out_valid || out_ready;
    wr_entry     = '{mode: cur.incr_mode, dest: wr_dest, src: wr_src,
                     len: cur.byte_length >> cur.split_log};
  end

  // shared unit operands per sequencer step
  always_comb begin
    alu_ctrl = '0;
    unique case (state)
      S_SUM: begin
        alu_ctrl.a = ALU_W'(cur.byte_length);
        alu_ctrl.b = (cur.op == OP_ADD) ? ALU_W'(entry_overhead) << cur.split_log
                                        : ALU_W'(entry_overhead);
      end
      S_BUDGET: begin
        alu_ctrl.a   = acc;
        alu_ctrl.b   = ALU_W'(used_budget);
        alu_ctrl.lim = (cur.op == OP_ADD && cur.blanking) ? bw_limit_blank : bw_limit;
      end
      S_COUNT: begin
        alu_ctrl.a   = ALU_W'(entry_count);
        alu_ctrl.b   = ALU_W'(chunks);
        alu_ctrl.lim = LIMIT_W'(QUEUE_DEPTH);
      end
      default: alu_ctrl = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result word
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit       = 1'b0;
    emit_item  = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.op)
            OP_ADD, OP_ARM: state_next = S_SUM;
            OP_RESET:       state_next = S_RESP;
            OP_DRAIN:       state_next = (entry_count != '0) ? S_DRAIN_RD : S_FILL;
          endcase
        end
      end
      S_SUM:    state_next = S_BUDGET;
      S_BUDGET: state_next = (cur.op == OP_ADD) ? S_COUNT : S_RESP;
      S_COUNT:  state_next = add_fail ? S_RESP : S_WRITE;
      S_WRITE: begin
        if (chunk_idx == chunk_last) state_next = S_RESP;
      end
      S_RESP: begin
        emit             = out_free;
        emit_item.kind   = KIND_STATUS;
        emit_item.status = status_bit;
        emit_item.last   = 1'b1;
        if (out_free) state_next = S_IDLE;
      end
      S_DRAIN_RD: state_next = S_DRAIN_OUT;
      S_DRAIN_OUT: begin
        emit                 = out_free;
        emit_item.kind       = KIND_COPY;
        emit_item.out_mode   = rd_data.mode;
        emit_item.out_dest   = rd_data.dest;
        emit_item.out_src    = rd_data.src;
        emit_item.out_length = rd_data.len;
        emit_item.last       = drain_at_end && !fill_armed;
        if (out_free) begin
          if (!drain_at_end)   state_next = S_DRAIN_RD;
          else if (fill_armed) state_next = S_FILL;
          else                 state_next = S_IDLE;
        end
      end
      S_FILL: begin
        emit           = out_free;
        emit_item.last = 1'b1;
        if (fill_armed) begin
          emit_item.kind       = KIND_FILL;
          emit_item.out_mode   = FILL_MODE;
          emit_item.out_dest   = fill_dest;
          emit_item.out_length = fill_length;
        end else begin
          emit_item.kind = KIND_STATUS;
        end
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // queue state, registers and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      used_budget    <= '0;
      fill_armed     <= 1'b0;
      fill_dest      <= '0;
      fill_length    <= '0;
      bw_limit       <= LIMIT_RST;
      bw_limit_blank <= LIMIT_BLANK_RST;
      entry_overhead <= OVH_RST;
      out_valid      <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LIMIT:       bw_limit       <= cfg_wdata;
          REG_LIMIT_BLANK: bw_limit_blank <= cfg_wdata;
          REG_OVERHEAD:    entry_overhead <= cfg_wdata[OVH_W-1:0];
          default:         ;
        endcase
      end

      // output register
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_item;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur        <= in_data;
            status_bit <= 1'b0;
            chunk_idx  <= '0;
            drain_idx  <= '0;
            wr_src     <= in_data.src_addr;
            wr_dest    <= in_data.dest_addr;
            if (in_data.op == OP_RESET) begin
              entry_count <= '0;
              used_budget <= '0;
              fill_armed  <= 1'b0;
            end
          end
        end
        S_SUM: acc <= alu_res.sum;
        S_BUDGET: begin
          acc         <= alu_res.sum;
          budget_fail <= alu_res.gt;
          // arm fill takes its decision here
          if (cur.op == OP_ARM) begin
            status_bit <= alu_res.gt;
            if (!alu_res.gt) begin
              fill_dest   <= cur.dest_addr;
              fill_length <= cur.byte_length;
              fill_armed  <= 1'b1;
            end
          end
        end
        S_COUNT: status_bit <= add_fail;
        S_WRITE: begin
          entry_count <= CNT_W'(entry_count + 1'b1);
          wr_src      <= wr_src + SRC_STEP;
          wr_dest     <= wr_dest + DEST_STEP;
          chunk_idx   <= CHUNK_W'(chunk_idx + 1'b1);
          if (chunk_idx == chunk_last) used_budget <= acc[LIMIT_W-1:0];
        end
        S_DRAIN_OUT: begin
          if (out_free) begin
            drain_idx <= CNT_W'(drain_idx + 1'b1);
            if (drain_at_end && !fill_armed) begin
              entry_count <= '0;
              used_budget <= '0;
            end
          end
        end
        S_FILL: begin
          if (out_free) begin
            entry_count <= '0;
            used_budget <= '0;
            fill_armed  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // descriptor memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_WRITE) mem[entry_count[IDX_W-1:0]] <= wr_entry;
    rd_data <= mem[drain_idx[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

// File: rtl/core/dqb_alu.sv
// Shared adder with limit compare, stepped through by the queue sequencer.
// Depends on dqb_pkg for the operand and result structs.
`timescale 1ns / 1ps
`default_nettype none

module dqb_alu (
  input  dqb_pkg::alu_ctrl_t ctrl,
  output dqb_pkg::alu_res_t  res
);
  import dqb_pkg::*;

  // sum at full width, flag when it exceeds the limit
  always_comb begin
    res.sum = ctrl.a + ctrl.b;
    res.gt  = res.sum > ALU_W'(ctrl.lim);
  end

endmodule

`default_nettype wire

// File: rtl/core/dqb_checker.sv
// Port-level checks for dma_descriptor_queue_budget, attached by bind.
// Depends on dqb_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module dqb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dqb_pkg::out_item_t out_data
);
  import dqb_pkg::*;

  // idle and empty after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // one request at a time: busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // status-only words always close their request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.last)
    else $error("status word not last");

  // fill descriptor is final, accepted, with zero source
  a_fill_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_FILL |->
      out_data.last && !out_data.status && out_data.out_src == '0)
    else $error("bad fill descriptor");

endmodule

bind dma_descriptor_queue_budget dqb_checker u_dqb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
